>>> design/dequ_pkg.sv
// ----------------------------------------------------------------------------
// dequ_pkg
// shared types and codes of the double-ended queue unit
// ----------------------------------------------------------------------------
`default_nettype none

package dequ_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned VAL_W  = 32;

  // request codes, the unused codes are ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_DROP_FRONT = 3'd2,
    REQ_DROP_REAR  = 3'd3,
    REQ_LIST       = 3'd4
  } req_type_t;

  // response kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_UNDER = 2'd2,
    KIND_OVER  = 2'd3
  } resp_kind_t;

endpackage : dequ_pkg

`default_nettype wire

>>> design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of signed 32-bit values in a ring memory
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per transfer; in_tuser carries the request code
//           (push front, push rear, drop front, drop rear, list) and
//           in_tdata the value to push
//   out_* : responses; out_tuser carries the kind (entry, empty listing,
//           underflow, overflow), out_tdata the listed value (zero
//           otherwise), out_tlast marks the final response of a request
//   a push or drop returns nothing on success; an
//   overflow, underflow or empty listing returns one response in the
//   register stage in the cycle after the request transfer
//   a listing of N entries streams one entry per cycle, while the receiver
//   takes them, through the single read port of the entry memory
//   (registered read); each entry passes the read data register and then
//   the output register; no new request is taken until the last entry
//   is in the output register
//   when the receiver stalls, the output register holds its response and
//   the unit stops taking requests and stops advancing the listing
//   reset empties the queue (front index and count to zero) at once; the
//   entry memory is not cleared, live entries are always written first
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
  import dequ_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [VAL_W-1:0]  in_tdata,   // [31:0] value_in
  input  wire logic [REQ_W-1:0]  in_tuser,   // [2:0] req_type
  // response channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [VAL_W-1:0]       out_tdata,  // [31:0] value_out
  output logic [KIND_W-1:0]      out_tuser,  // [1:0] resp_kind
  output logic                   out_tlast   // last
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  // ring position (base + offset) mod DEPTH, both operands below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // queue control state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;       // listing position from front

  // output register
  logic             ovalid_r, ovalid_nxt;
  logic [VAL_W-1:0] odata_r, odata_nxt;
  resp_kind_t       okind_r, okind_nxt;
  logic             olast_r, olast_nxt;

  // entry memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data_r;

  logic             slot_free;
  logic             in_xfer;
  logic             is_full;
  logic             is_empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic             list_last;
  req_type_t        req;

  assign slot_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign list_last = (CNT_W'(pos_r) + CNT_W'(1)) == count_r;
  assign req       = req_type_t'(in_tuser);

  // read address follows the next listing position, so the read data
  // register always holds the entry at pos_r while listing
  assign rd_addr = ring_add(front_r, pos_nxt);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    wr_en      = 1'b0;
    wr_addr    = front_dec;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (req) inside
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
              if (is_full) begin
                ovalid_nxt = 1'b1;
                okind_nxt  = KIND_OVER;
                odata_nxt  = '0;
                olast_nxt  = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (req == REQ_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  wr_addr   = front_dec;
                end else begin
                  wr_addr = ring_add(front_r, IDX_W'(count_r));
                end
              end
            end
            REQ_DROP_FRONT, REQ_DROP_REAR: begin
              if (is_empty) begin
                ovalid_nxt = 1'b1;
                okind_nxt  = KIND_UNDER;
                odata_nxt  = '0;
                olast_nxt  = 1'b1;
              end else begin
                count_nxt = count_r - 1'b1;
                if (req == REQ_DROP_FRONT) begin
                  front_nxt = front_inc;
                end
              end
            end
            REQ_LIST: begin
              if (is_empty) begin
                ovalid_nxt = 1'b1;
                okind_nxt  = KIND_EMPTY;
                odata_nxt  = '0;
                olast_nxt  = 1'b1;
              end else begin
                state_nxt = ST_LIST;
                pos_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_ENTRY;
          odata_nxt  = rd_data_r;
          olast_nxt  = list_last;
          if (list_last) begin
            state_nxt = ST_IDLE;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

`ifndef ASSERT_OFF
  // the count never goes past the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a listing only runs over a non-empty queue and stays inside it
  a_list_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> (!is_empty && (CNT_W'(pos_r) < count_r)))
    else $error("listing position outside the live window");

  // a successful push grows the queue by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !is_full && (req == REQ_PUSH_FRONT || req == REQ_PUSH_REAR))
    |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow the queue");

  // a listing leaves the queue state alone
  a_list_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |=> ($stable(count_r) && $stable(front_r)))
    else $error("queue state changed during listing");

  // every response that is not a listed entry closes its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && okind_r != KIND_ENTRY) |-> olast_r)
    else $error("error or empty response without last");
`endif

endmodule : double_ended_queue_unit

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the double-ended queue unit: a mirror of the ring
// store predicts every response, random pushes, drops and listings run
// under varying back-pressure on both streams
// ----------------------------------------------------------------------------

// mirror of the queue state plus the responses it still owes
class deque_mirror;

  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    dequ_pkg::resp_kind_t kind;
    logic [31:0]          value;
    logic                 last;
  } resp_t;

  logic [31:0] slots [DEPTH];
  logic [5:0]  head;
  logic [6:0]  fill;
  resp_t       pending [$];
  int          errors;

  function new();
    head   = '0;
    fill   = '0;
    errors = 0;
  endfunction

  task report(string what);
    $display("tb: mismatch: %s", what);
    errors++;
  endtask

  function void owe(dequ_pkg::resp_kind_t kind, logic [31:0] value, logic last);
    resp_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    pending.push_back(r);
  endfunction

  // called once per accepted request transfer
  function void accept_request(logic [2:0] req, logic [31:0] value);
    logic [5:0] slot;
    case (req)
      dequ_pkg::REQ_PUSH_FRONT: begin
        if (fill >= 7'(DEPTH)) begin
          owe(dequ_pkg::KIND_OVER, '0, 1'b1);
        end else begin
          head        = head - 6'd1;
          slots[head] = value;
          fill        = fill + 7'd1;
        end
      end
      dequ_pkg::REQ_PUSH_REAR: begin
        if (fill >= 7'(DEPTH)) begin
          owe(dequ_pkg::KIND_OVER, '0, 1'b1);
        end else begin
          slot        = head + fill[5:0];
          slots[slot] = value;
          fill        = fill + 7'd1;
        end
      end
      dequ_pkg::REQ_DROP_FRONT: begin
        if (fill == 7'd0) begin
          owe(dequ_pkg::KIND_UNDER, '0, 1'b1);
        end else begin
          head = head + 6'd1;
          fill = fill - 7'd1;
        end
      end
      dequ_pkg::REQ_DROP_REAR: begin
        if (fill == 7'd0) begin
          owe(dequ_pkg::KIND_UNDER, '0, 1'b1);
        end else begin
          fill = fill - 7'd1;
        end
      end
      dequ_pkg::REQ_LIST: begin
        if (fill == 7'd0) begin
          owe(dequ_pkg::KIND_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(fill); i++) begin
            slot = head + 6'(i);
            owe(dequ_pkg::KIND_ENTRY, slots[slot], (i + 1 == int'(fill)));
          end
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
  endfunction

  // called once per accepted response transfer
  task check_response(logic [1:0] kind, logic [31:0] value, logic last);
    resp_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected response kind %0d value %h last %b",
                       kind, value, last));
      return;
    end
    want = pending.pop_front();
    if (kind !== want.kind)
      report($sformatf("kind %0d, wanted %0d", kind, want.kind));
    if (value !== want.value)
      report($sformatf("value %h, wanted %h", value, want.value));
    if (last !== want.last)
      report($sformatf("last %b, wanted %b", last, want.last));
  endtask

endclass

module tb;

  import dequ_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  // a full listing streams one entry per cycle while the receiver is ready, plus read latency
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
  localparam int unsigned LIMIT        = 1_000_000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [VAL_W-1:0]  in_tdata   = '0;   // [31:0] value_in
  logic [REQ_W-1:0]  in_tuser   = '0;   // [2:0] req_type
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [VAL_W-1:0]  out_tdata;         // [31:0] value_out
  logic [KIND_W-1:0] out_tuser;         // [1:0] resp_kind
  logic              out_tlast;

  deque_mirror mirror;

  // idle rates in percent, written by the stimulus thread only
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 75;
  // counted request transfers, ignored codes excluded
  int unsigned items_sent    = 0;
  // long receiver hold-offs asked by the stimulus, served by the receiver
  int unsigned hold_requests = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // response side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      mirror.check_response(out_tuser, out_tdata, out_tlast);
    if (holds_taken != hold_requests) begin
      hold_left   = HOLD_CYCLES;
      holds_taken = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // push values lean on the extremes now and then
  function automatic logic [31:0] rand_value();
    case ($urandom_range(9, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one request transfer; valid stays high afterwards so the next call
  // either replaces the item or drops valid for a gap
  task automatic send_req(input logic [2:0] req, input logic [31:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= value;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    mirror.accept_request(req, value);
    if (req <= REQ_LIST) items_sent++;
  endtask

  // stop offering and wait for every owed response
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending.size() != 0) @(posedge clk);
  endtask

  task automatic push_any();
    if ($urandom_range(1, 0) != 0) send_req(REQ_PUSH_FRONT, rand_value());
    else                           send_req(REQ_PUSH_REAR, rand_value());
  endtask

  task automatic drop_any();
    if ($urandom_range(1, 0) != 0) send_req(REQ_DROP_FRONT, $urandom);
    else                           send_req(REQ_DROP_REAR, $urandom);
  endtask

  task automatic random_op();
    int unsigned pick;
    logic [2:0]  code;
    pick = $urandom_range(99, 0);
    if (pick < 26)      send_req(REQ_PUSH_FRONT, rand_value());
    else if (pick < 52) send_req(REQ_PUSH_REAR, rand_value());
    else if (pick < 70) send_req(REQ_DROP_FRONT, $urandom);
    else if (pick < 88) send_req(REQ_DROP_REAR, $urandom);
    else if (pick < 96) send_req(REQ_LIST, $urandom);
    else begin
      // one of the unused codes above list
      code = REQ_LIST + 3'($urandom_range(3, 1));
      send_req(code, $urandom);
    end
  endtask

  // grow to full, overflow once or twice, then list everything
  task automatic fill_round();
    while (mirror.fill < 7'(DEPTH)) push_any();
    repeat ($urandom_range(2, 1)) push_any();
    send_req(REQ_LIST, $urandom);
  endtask

  // shrink to empty, underflow, then list the empty queue
  task automatic drain_round();
    while (mirror.fill != 7'd0) drop_any();
    drop_any();
    send_req(REQ_LIST, $urandom);
  endtask

  task automatic mixed_round();
    repeat ($urandom_range(20, 6)) random_op();
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input bit start_full);
    int unsigned target;
    int unsigned pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target        = items_sent + PHASE_ITEMS;
    if (start_full) fill_round();
    while (items_sent < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 10)      fill_round();
      else if (pick < 25) drain_round();
      else                mixed_round();
    end
    settle();
  endtask

  // short directed opening
  task automatic directed();
    // empty queue: listing and both drops
    send_req(REQ_LIST, 32'h0000_0000);
    send_req(REQ_DROP_FRONT, 32'hffff_ffff);
    send_req(REQ_DROP_REAR, 32'h0000_0000);
    // extremes at both ends
    send_req(REQ_PUSH_FRONT, 32'h8000_0000);
    send_req(REQ_PUSH_REAR, 32'h7fff_ffff);
    send_req(REQ_PUSH_FRONT, 32'h0000_0000);
    send_req(REQ_PUSH_REAR, 32'hffff_ffff);
    send_req(REQ_LIST, 32'h5555_5555);
    // unused codes must be ignored
    for (int k = 1; k <= 3; k++) send_req(REQ_LIST + 3'(k), 32'hffff_ffff);
    send_req(REQ_DROP_FRONT, 32'h0000_0000);
    send_req(REQ_DROP_REAR, 32'h0000_0000);
    send_req(REQ_LIST, 32'h0000_0000);
    // drop the last entry from either end, queue goes empty in place
    send_req(REQ_DROP_FRONT, 32'h0000_0000);
    send_req(REQ_DROP_REAR, 32'h0000_0000);
    send_req(REQ_LIST, 32'h0000_0000);
    send_req(REQ_DROP_FRONT, 32'h0000_0000);
    // refill after emptying, front index kept where it stopped
    send_req(REQ_PUSH_REAR, 32'haaaa_aaaa);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_LIST, 32'h0000_0000);
  endtask

  initial begin
    mirror = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed();
    settle();

    // slow-ish sender, very lazy receiver, start from a full queue
    run_phase(28, 75, 1'b1);
    // lazy sender, mostly ready receiver
    run_phase(75, 28, 1'b0);

    // receiver holds off for a long stretch while requests keep coming,
    // the output register fills and input ready must drop
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    fill_round();
    send_req(REQ_LIST, $urandom);
    mixed_round();
    settle();

    // no idling on either side
    run_phase(0, 0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.pending.size() != 0)
      mirror.report($sformatf("%0d responses never arrived", mirror.pending.size()));
    if (mirror.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
